### rtl/hrm_pkg.sv
package hrm_pkg;

   localparam int unsigned CH_W    = 8;
   localparam int unsigned SUM_W   = 24;
   localparam int unsigned CNT_W   = 17;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned CSR_W   = 2;
   localparam int unsigned LANES   = 3;
   localparam int unsigned QUOT_W  = 8;
   // one saturation check plus one step per quotient bit
   localparam int unsigned STEPS   = QUOT_W + 1;
   localparam int unsigned STEP_W  = $clog2(STEPS);

   localparam logic [MODE_W-1:0] MODE_ACCUM   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_TOL_HUE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_TOL_SAT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_TOL_VAL = 2'd2;

   localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

   typedef struct packed {
      logic accum;
      logic load;
      logic step;
      logic sat_chk;
      logic commit;
   } lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic cmp;
      logic status;
   } rsp_ctrl_type;

endpackage

### rtl/hrm_if.sv
interface hrm_req_if;
   import hrm_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [CH_W-1:0]   pix_hue;
   logic [CH_W-1:0]   pix_sat;
   logic [CH_W-1:0]   pix_val;
   logic [CNT_W-1:0]  pixel_count;

   modport source (output valid, mode, pix_hue, pix_sat, pix_val, pixel_count, input ready);
   modport sink   (input valid, mode, pix_hue, pix_sat, pix_val, pixel_count, output ready);
endinterface

interface hrm_rsp_if;
   import hrm_pkg::*;

   logic            valid;
   logic            ready;
   logic            match;
   logic [CH_W-1:0] mean_hue;
   logic [CH_W-1:0] mean_sat;
   logic [CH_W-1:0] mean_val;
   logic            status;

   modport source (output valid, match, mean_hue, mean_sat, mean_val, status, input ready);
   modport sink   (input valid, match, mean_hue, mean_sat, mean_val, status, output ready);
endinterface

### rtl/hsv_region_mean_match.sv
// Accumulate, compare, zero-count finish and unused-mode beats give their result in the cycle
//   after acceptance; a finish beat with a nonzero count gives it after ST_DIV and ST_COMMIT.
// Throughput: one beat per cycle while the output register is not stalled, except a finish
//   beat with a nonzero count: the input is held for the shared 9-step restoring divide
//   sequence (one compare-subtract per lane per cycle, three lanes in parallel), then ST_COMMIT.
// Reset clears the channel sums, the reference color, the tolerances and the output valid flag.
module hsv_region_mean_match #(
   parameter int unsigned MAX_PIXELS = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   hrm_req_if.sink                   req_bus,
   hrm_rsp_if.source                 rsp_bus,
   input  logic                      csr_we,
   input  logic [hrm_pkg::CSR_W-1:0] csr_index,
   input  logic [hrm_pkg::CH_W-1:0]  csr_wdata
);
   import hrm_pkg::*;

   localparam int unsigned DIV_FULL = $clog2(MAX_PIXELS + 1);
   localparam int unsigned DIV_W    = (DIV_FULL > CNT_W) ? CNT_W : DIV_FULL;
   localparam int unsigned CMP_W    = (DIV_W + QUOT_W > SUM_W) ? DIV_W + QUOT_W : SUM_W;
   localparam logic [31:0] MAX_CNT  = 32'(MAX_PIXELS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIV    = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CMP_W-1:0]  dsh_ff, dsh_in;
   logic [CH_W-1:0]   tol_ff [LANES];

   logic              accept, out_busy;
   logic              is_accum, is_finish, is_cmp, cnt_zero;
   logic [31:0]       cnt_wide;
   logic [DIV_W-1:0]  divisor;
   lane_ctrl_type     lane_ctrl;
   rsp_ctrl_type      rsp_ctrl;
   logic [CH_W-1:0]   pix  [LANES];
   logic [CH_W-1:0]   mean [LANES];
   logic [LANES-1:0]  win;

   assign req_bus.ready = (state_ff == ST_IDLE) && !out_busy;
   assign accept        = req_bus.valid && req_bus.ready;

   assign is_accum  = req_bus.mode == MODE_ACCUM;
   assign is_finish = req_bus.mode == MODE_FINISH;
   assign is_cmp    = req_bus.mode == MODE_COMPARE;
   assign cnt_zero  = req_bus.pixel_count == '0;

   assign cnt_wide = 32'(req_bus.pixel_count);
   assign divisor  = (cnt_wide > MAX_CNT) ? MAX_CNT[DIV_W-1:0] : cnt_wide[DIV_W-1:0];

   assign pix[0] = req_bus.pix_hue;
   assign pix[1] = req_bus.pix_sat;
   assign pix[2] = req_bus.pix_val;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      dsh_in    = dsh_ff;
      lane_ctrl = '0;
      rsp_ctrl  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lane_ctrl.accum = is_accum;
               if (is_finish && !cnt_zero) begin
                  lane_ctrl.load = 1'b1;
                  dsh_in         = CMP_W'(divisor) << QUOT_W;
                  step_in        = '0;
                  state_in       = ST_DIV;
               end else begin
                  rsp_ctrl.load   = 1'b1;
                  rsp_ctrl.cmp    = is_cmp;
                  rsp_ctrl.status = is_finish;
               end
            end
         end
         ST_DIV: begin
            lane_ctrl.step    = 1'b1;
            lane_ctrl.sat_chk = step_ff == '0;
            // advance to the next lower quotient bit
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            lane_ctrl.commit = 1'b1;
            rsp_ctrl.load    = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      dsh_ff <= dsh_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            tol_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TOL_HUE: tol_ff[0] <= csr_wdata;
            CSR_TOL_SAT: tol_ff[1] <= csr_wdata;
            CSR_TOL_VAL: tol_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      hrm_lane #(
         .CMP_W (CMP_W)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .pix    (pix[g]),
         .tol    (tol_ff[g]),
         .dsh    (dsh_ff),
         .mean   (mean[g]),
         .in_win (win[g])
      );
   end

   hrm_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (rsp_ctrl),
      .win      (win),
      .mean_hue (mean[0]),
      .mean_sat (mean[1]),
      .mean_val (mean[2]),
      .busy     (out_busy),
      .rsp      (rsp_bus)
   );

   // the output register is empty for the whole divide
   a_div_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_bus.valid)
      else $error("result pending during divide");

   a_finish_starts_div: assert property (@(posedge clock) disable iff (reset)
      (accept && is_finish && !cnt_zero) |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("finish beat did not start divide");

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> rsp_bus.valid && (state_ff == ST_IDLE))
      else $error("commit did not produce a result");

   a_one_ctrl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({lane_ctrl.load, lane_ctrl.step, lane_ctrl.commit}))
      else $error("conflicting lane controls");

endmodule

### rtl/hrm_lane.sv
module hrm_lane #(
   parameter int unsigned CMP_W = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hrm_pkg::lane_ctrl_type      ctrl,
   input  logic [hrm_pkg::CH_W-1:0]    pix,
   input  logic [hrm_pkg::CH_W-1:0]    tol,
   input  logic [CMP_W-1:0]            dsh,
   output logic [hrm_pkg::CH_W-1:0]    mean,
   output logic                        in_win
);
   import hrm_pkg::*;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              sat_ff, sat_in;
   logic [CH_W-1:0]   ref_ff, ref_in;

   logic [SUM_W:0]    sum_wide;
   logic [CMP_W-1:0]  rem_ext, rem_sub;
   logic              ge;
   logic [CH_W-1:0]   quot_mean;
   logic signed [CH_W+1:0] p_s, r_s, h_s;

   assign sum_wide  = {1'b0, sum_ff} + (SUM_W+1)'(pix);
   assign rem_ext   = CMP_W'(rem_ff);
   assign ge        = rem_ext >= dsh;
   assign rem_sub   = rem_ext - dsh;
   assign quot_mean = sat_ff ? CH_MAX : CH_W'(quot_ff);
   assign mean      = ctrl.commit ? quot_mean : ref_ff;

   // window test at full precision, signed, no wrap
   assign p_s    = $signed({2'b00, pix});
   assign r_s    = $signed({2'b00, ref_ff});
   assign h_s    = $signed({3'b000, tol[CH_W-1:1]});
   assign in_win = (p_s <= r_s + h_s) && (p_s >= r_s - h_s);

   always_comb begin
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      sat_in  = sat_ff;
      ref_in  = ref_ff;
      if (ctrl.accum) begin
         sum_in = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      end
      if (ctrl.load) begin
         rem_in  = sum_ff;
         quot_in = '0;
         sat_in  = 1'b0;
      end
      if (ctrl.step) begin
         if (ctrl.sat_chk) begin
            sat_in = ge;
         end else begin
            quot_in = {quot_ff[QUOT_W-2:0], ge};
            if (ge) begin
               rem_in = rem_sub[SUM_W-1:0];
            end
         end
      end
      if (ctrl.commit) begin
         ref_in = quot_mean;
         sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         ref_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         ref_ff <= ref_in;
         sat_ff <= sat_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

endmodule

### rtl/hrm_merge.sv
module hrm_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  hrm_pkg::rsp_ctrl_type     ctrl,
   input  logic [hrm_pkg::LANES-1:0] win,
   input  logic [hrm_pkg::CH_W-1:0]  mean_hue,
   input  logic [hrm_pkg::CH_W-1:0]  mean_sat,
   input  logic [hrm_pkg::CH_W-1:0]  mean_val,
   output logic                      busy,
   hrm_rsp_if.source                 rsp
);
   import hrm_pkg::*;

   logic            valid_ff, valid_in;
   logic            match_ff, match_in;
   logic            status_ff, status_in;
   logic [CH_W-1:0] hue_ff, hue_in;
   logic [CH_W-1:0] sat_ff, sat_in;
   logic [CH_W-1:0] val_ff, val_in;

   assign busy = valid_ff && !rsp.ready;

   always_comb begin
      valid_in  = valid_ff && !rsp.ready;
      match_in  = match_ff;
      status_in = status_ff;
      hue_in    = hue_ff;
      sat_in    = sat_ff;
      val_in    = val_ff;
      if (ctrl.load) begin
         valid_in  = 1'b1;
         match_in  = ctrl.cmp && (&win);
         status_in = ctrl.status;
         hue_in    = mean_hue;
         sat_in    = mean_sat;
         val_in    = mean_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      match_ff  <= match_in;
      status_ff <= status_in;
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      val_ff    <= val_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.match    = match_ff;
   assign rsp.status   = status_ff;
   assign rsp.mean_hue = hue_ff;
   assign rsp.mean_sat = sat_ff;
   assign rsp.mean_val = val_ff;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import hrm_pkg::*;

   localparam int CLK_PERIOD_NS  = 12;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int unsigned PIXEL_LIMIT = 65536;
   localparam int unsigned SUM_LIMIT   = (1 << SUM_W) - 1;
   localparam int unsigned COUNT_MAX   = (1 << CNT_W) - 1;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CH_W-1:0]   hue;
      logic [CH_W-1:0]   sat;
      logic [CH_W-1:0]   val;
      logic [CNT_W-1:0]  count;
   } pixel_beat_type;

   typedef struct packed {
      logic            match;
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] sat;
      logic [CH_W-1:0] val;
      logic            status;
   } color_rsp_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_W-1:0]  csr_index;
   logic [CH_W-1:0]   csr_wdata;

   hrm_req_if req_bus ();
   hrm_rsp_if rsp_bus ();

   hsv_region_mean_match #(
      .MAX_PIXELS (PIXEL_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // color model state
   logic [SUM_W-1:0] chan_sum [LANES];
   logic [CH_W-1:0]  ref_chan [LANES];
   logic [CH_W-1:0]  tol_chan [LANES];

   color_rsp_type mean_match_q [$];
   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;

   always #(CLK_PERIOD_NS / 2) clock = ~clock;

   initial begin
      #(CLK_PERIOD_NS * TIMEOUT_CYCLES);
      $display("testbench: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      color_rsp_type got;
      color_rsp_type want;
      logic          bad;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.match  = rsp_bus.match;
         got.hue    = rsp_bus.mean_hue;
         got.sat    = rsp_bus.mean_sat;
         got.val    = rsp_bus.mean_val;
         got.status = rsp_bus.status;
         if (mean_match_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: match=%0d mean=%0d/%0d/%0d status=%0d",
                        got.match, got.hue, got.sat, got.val, got.status);
         end else begin
            want = mean_match_q.pop_front();
            bad = (got.match !== want.match) || (got.hue !== want.hue) ||
                  (got.sat !== want.sat) || (got.val !== want.val) ||
                  (got.status !== want.status);
            if (bad) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result mismatch: expected match=%0d mean=%0d/%0d/%0d status=%0d",
                           want.match, want.hue, want.sat, want.val, want.status);
                  $display("                 got      match=%0d mean=%0d/%0d/%0d status=%0d",
                           got.match, got.hue, got.sat, got.val, got.status);
               end
            end
         end
      end
   end

   function automatic bit in_tolerance(logic [CH_W-1:0] px, logic [CH_W-1:0] center,
                                       logic [CH_W-1:0] tol);
      int p;
      int c;
      int h;
      p = px;
      c = center;
      h = tol >> 1;
      return (p <= c + h) && (p >= c - h);
   endfunction

   // advance the color model by one accepted beat and return its result
   function automatic color_rsp_type step_color_model(pixel_beat_type b);
      color_rsp_type   r;
      logic [CH_W-1:0] px [LANES];
      int unsigned     divisor;
      int unsigned     quot;
      int unsigned     acc;
      bit              hit;
      px[0] = b.hue;
      px[1] = b.sat;
      px[2] = b.val;
      r = '0;
      hit = 1'b1;
      case (b.mode)
         MODE_ACCUM: begin
            for (int i = 0; i < LANES; i++) begin
               acc = chan_sum[i] + px[i];
               chan_sum[i] = (acc > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : acc[SUM_W-1:0];
            end
         end
         MODE_FINISH: begin
            if (b.count == 0) begin
               r.status = 1'b1;
            end else begin
               divisor = (b.count > PIXEL_LIMIT) ? PIXEL_LIMIT : b.count;
               for (int i = 0; i < LANES; i++) begin
                  quot = chan_sum[i] / divisor;
                  ref_chan[i] = (quot > CH_MAX) ? CH_MAX : quot[CH_W-1:0];
                  chan_sum[i] = '0;
               end
            end
         end
         MODE_COMPARE: begin
            for (int i = 0; i < LANES; i++)
               if (!in_tolerance(px[i], ref_chan[i], tol_chan[i])) hit = 1'b0;
            r.match = hit;
         end
         default: ;
      endcase
      r.hue = ref_chan[0];
      r.sat = ref_chan[1];
      r.val = ref_chan[2];
      return r;
   endfunction

   function automatic pixel_beat_type make_beat(logic [MODE_W-1:0] mode, int unsigned h,
                                                int unsigned s, int unsigned v,
                                                int unsigned count);
      pixel_beat_type b;
      b.mode  = mode;
      b.hue   = h[CH_W-1:0];
      b.sat   = s[CH_W-1:0];
      b.val   = v[CH_W-1:0];
      b.count = count[CNT_W-1:0];
      return b;
   endfunction

   function automatic int unsigned rand_channel();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 0;
      if (roll == 1) return CH_MAX;
      return $urandom_range(CH_MAX);
   endfunction

   // pick a pixel channel around the edges of the current window
   function automatic int unsigned near_window(int lane);
      int c;
      int h;
      int px;
      c = ref_chan[lane];
      h = tol_chan[lane] >> 1;
      case ($urandom_range(5))
         0:       px = c - h - 1;
         1:       px = c - h;
         2:       px = c + h;
         3:       px = c + h + 1;
         default: px = c - h + $urandom_range(2 * h);
      endcase
      if (px < 0) px = 0;
      if (px > CH_MAX) px = CH_MAX;
      return px;
   endfunction

   function automatic int unsigned pick_count(int accumulated);
      int roll;
      roll = $urandom_range(9);
      if (roll < 7) return accumulated;
      if (roll == 7) return 0;
      if (roll == 8) return $urandom_range(1, 16);
      return $urandom_range(PIXEL_LIMIT, COUNT_MAX);
   endfunction

   task automatic send_pixel_beat(pixel_beat_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= b.mode;
      req_bus.pix_hue     <= b.hue;
      req_bus.pix_sat     <= b.sat;
      req_bus.pix_val     <= b.val;
      req_bus.pixel_count <= b.count;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      mean_match_q.push_back(step_color_model(b));
   endtask

   // drop valid and hold until every expected result is back
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (mean_match_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerances(int unsigned h, int unsigned s, int unsigned v);
      logic [CSR_W-1:0] idx  [LANES];
      int unsigned      data [LANES];
      idx  = '{CSR_TOL_HUE, CSR_TOL_SAT, CSR_TOL_VAL};
      data = '{h, s, v};
      for (int i = 0; i < LANES; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i][CH_W-1:0];
         @(posedge clock);
         tol_chan[i] = data[i][CH_W-1:0];
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_compare_after_reset();
      send_pixel_beat(make_beat(MODE_COMPARE, 0, 0, 0, 0));
      send_pixel_beat(make_beat(MODE_COMPARE, 1, 0, 0, COUNT_MAX));
      send_pixel_beat(make_beat(MODE_COMPARE, 0, 0, CH_MAX, 0));
      send_pixel_beat(make_beat(MODE_UNUSED, CH_MAX, CH_MAX, CH_MAX, COUNT_MAX));
      send_pixel_beat(make_beat(MODE_FINISH, 0, 0, 0, 0));
   endtask

   task automatic test_finish_mean();
      send_pixel_beat(make_beat(MODE_ACCUM, CH_MAX, CH_MAX, CH_MAX, 0));
      send_pixel_beat(make_beat(MODE_ACCUM, 0, 0, 0, COUNT_MAX));
      send_pixel_beat(make_beat(MODE_ACCUM, CH_MAX, 128, 1, 0));
      send_pixel_beat(make_beat(MODE_FINISH, CH_MAX, CH_MAX, CH_MAX, 2));
      // a single-pixel divisor pushes the mean past the channel range
      send_pixel_beat(make_beat(MODE_ACCUM, 200, 100, 50, 0));
      send_pixel_beat(make_beat(MODE_ACCUM, 200, 100, 50, 0));
      send_pixel_beat(make_beat(MODE_FINISH, 0, 0, 0, 1));
   endtask

   task automatic test_window_edges();
      wait_for_results();
      write_tolerances(CH_MAX, 2, 1);
      send_pixel_beat(make_beat(MODE_COMPARE, 128, 199, 100, 0));
      send_pixel_beat(make_beat(MODE_COMPARE, 127, 200, 100, 0));
      send_pixel_beat(make_beat(MODE_COMPARE, 255, 201, 100, 0));
      send_pixel_beat(make_beat(MODE_COMPARE, 255, 202, 100, 0));
      send_pixel_beat(make_beat(MODE_COMPARE, 255, 200, 101, 0));
      // divisor above the pixel limit clamps to it
      send_pixel_beat(make_beat(MODE_ACCUM, CH_MAX, CH_MAX, CH_MAX, 0));
      send_pixel_beat(make_beat(MODE_FINISH, 0, 0, 0, COUNT_MAX));
   endtask

   task automatic test_full_scale_sums();
      // a run of pixels at full-scale hue and saturation, then a finish over the exact count
      for (int i = 0; i < 24; i++)
         send_pixel_beat(make_beat(MODE_ACCUM, CH_MAX, CH_MAX, 128,
                                   $urandom_range(COUNT_MAX)));
      send_pixel_beat(make_beat(MODE_FINISH, 0, 0, 0, 24));
   endtask

   task automatic test_random_sequences(int target);
      int             sent;
      int             k;
      int             n_cmp;
      pixel_beat_type b;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 78) begin
            k = $urandom_range(1, 12);
            repeat (k)
               send_pixel_beat(make_beat(MODE_ACCUM, rand_channel(), rand_channel(),
                                         rand_channel(), $urandom_range(COUNT_MAX)));
            send_pixel_beat(make_beat(MODE_FINISH, $urandom_range(CH_MAX),
                                      $urandom_range(CH_MAX), $urandom_range(CH_MAX),
                                      pick_count(k)));
            n_cmp = $urandom_range(1, 6);
            repeat (n_cmp)
               send_pixel_beat(make_beat(MODE_COMPARE, near_window(0), near_window(1),
                                         near_window(2), $urandom_range(COUNT_MAX)));
            sent += k + 1 + n_cmp;
         end else begin
            b = make_beat(MODE_W'($urandom_range(3)), $urandom_range(CH_MAX),
                          $urandom_range(CH_MAX), $urandom_range(CH_MAX),
                          $urandom_range(COUNT_MAX));
            send_pixel_beat(b);
            if (b.mode != MODE_UNUSED) sent++;
         end
      end
   endtask

   task automatic run_traffic_phase(int send_pct, int recv_pct, int unsigned fixed_h,
                                    int unsigned fixed_s, int unsigned fixed_v);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      wait_for_results();
      write_tolerances($urandom_range(CH_MAX), $urandom_range(CH_MAX),
                       $urandom_range(CH_MAX));
      test_random_sequences(260);
      wait_for_results();
      write_tolerances(fixed_h, fixed_s, fixed_v);
      test_random_sequences(260);
   endtask

   initial begin
      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_TOL_HUE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.mode        = MODE_ACCUM;
      req_bus.pix_hue     = '0;
      req_bus.pix_sat     = '0;
      req_bus.pix_val     = '0;
      req_bus.pixel_count = '0;
      rsp_bus.ready       = 1'b0;
      mismatch_count      = 0;
      send_idle_pct       = 38;
      recv_idle_pct       = 48;
      for (int i = 0; i < LANES; i++) begin
         chan_sum[i] = '0;
         ref_chan[i] = '0;
         tol_chan[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_compare_after_reset();
      test_finish_mean();
      test_window_edges();
      test_full_scale_sums();
      run_traffic_phase(38, 48, CH_MAX, CH_MAX, CH_MAX);
      run_traffic_phase(48, 38, 0, 0, 0);
      run_traffic_phase(0, 0, 1, 254, 128);
      wait_for_results();

      repeat (24) @(posedge clock);
      if (mismatch_count == 0 && mean_match_q.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
